// ===== hw/rtl/dlq_pkg.sv =====
// ----------------------------------------------------------------------------
// dlq_pkg
// Shared types and constants for the deadline ordered queue: operation and
// status codes, fixed field widths and parameter defaults.
// ----------------------------------------------------------------------------
package dlq_pkg;

  // Parameter defaults
  localparam int unsigned QueueDepthDef   = 16;
  localparam int unsigned IdBitsDef       = 10;
  localparam int unsigned DeadlineBitsDef = 32;

  // Fixed field widths
  localparam int unsigned FuncW   = 2;
  localparam int unsigned PosW    = 4;
  localparam int unsigned StatusW = 2;

  // Operation codes; the remaining code is ignored
  typedef enum logic [FuncW-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_READ   = 2'd2
  } func_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_e;

endpackage

// ===== hw/rtl/dlq_store.sv =====
// ----------------------------------------------------------------------------
// dlq_store
// Entry memory: one write port and one read port, read data registered.
// Each word packs {job id, deadline}.
// ----------------------------------------------------------------------------
module dlq_store #(
  parameter int unsigned QUEUE_DEPTH = dlq_pkg::QueueDepthDef,
  parameter int unsigned ENTRY_W     = dlq_pkg::IdBitsDef + dlq_pkg::DeadlineBitsDef,
  parameter int unsigned IDX_W       = $clog2(QUEUE_DEPTH)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [IDX_W-1:0]   waddr_i,
  input  logic [ENTRY_W-1:0] wdata_i,
  input  logic               re_i,
  input  logic [IDX_W-1:0]   raddr_i,
  output logic [ENTRY_W-1:0] rdata_o
);
  import dlq_pkg::*;

  logic [ENTRY_W-1:0] mem_q [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  // Write the addressed entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read word
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dlq_seq.sv =====
// ----------------------------------------------------------------------------
// dlq_seq
// Operation sequencer: walks the entry memory one slot at a time to shift
// entries on insert and remove, keeps the entry count and drives the result.
// ----------------------------------------------------------------------------
module dlq_seq #(
  parameter int unsigned QUEUE_DEPTH   = dlq_pkg::QueueDepthDef,
  parameter int unsigned ID_BITS       = dlq_pkg::IdBitsDef,
  parameter int unsigned DEADLINE_BITS = dlq_pkg::DeadlineBitsDef,
  parameter int unsigned ENTRY_W       = ID_BITS + DEADLINE_BITS,
  parameter int unsigned IDX_W         = $clog2(QUEUE_DEPTH),
  parameter int unsigned CNT_W         = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request side
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [dlq_pkg::FuncW-1:0]    func_i,
  input  logic [ID_BITS-1:0]           item_id_i,
  input  logic [DEADLINE_BITS-1:0]     item_deadline_i,
  input  logic [dlq_pkg::PosW-1:0]     position_i,
  // result side
  output logic                         done_o,
  output logic [dlq_pkg::StatusW-1:0]  status_o,
  output logic [ID_BITS-1:0]           read_id_o,
  output logic [DEADLINE_BITS-1:0]     read_deadline_o,
  output logic [CNT_W-1:0]             occupancy_o,
  // memory side
  output logic                         mem_we_o,
  output logic [IDX_W-1:0]             mem_waddr_o,
  output logic [ENTRY_W-1:0]           mem_wdata_o,
  output logic                         mem_re_o,
  output logic [IDX_W-1:0]             mem_raddr_o,
  input  logic [ENTRY_W-1:0]           mem_rdata_i
);
  import dlq_pkg::*;

  localparam int unsigned CMP_W = (CNT_W > PosW) ? CNT_W : PosW;
  localparam logic [CNT_W-1:0] DepthC = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] OneC   = CNT_W'(1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_INS_RD  = 6'b000010,
    S_INS_CMP = 6'b000100,
    S_INS_PUT = 6'b001000,
    S_REM_RD  = 6'b010000,
    S_REM_CHK = 6'b100000
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       k_q, k_d;
  logic                   found_q, found_d;
  logic                   rd_pend_q, rd_pend_d;
  logic [ID_BITS-1:0]     id_q, id_d;
  logic [DEADLINE_BITS-1:0] dl_q, dl_d;

  logic                     done_q, done_d;
  logic [StatusW-1:0]       status_q, status_d;
  logic [ID_BITS-1:0]       rid_q, rid_d;
  logic [DEADLINE_BITS-1:0] rdl_q, rdl_d;

  logic [CNT_W-1:0]         k_m1;
  logic [CMP_W-1:0]         pos_ext;
  logic [CMP_W-1:0]         cnt_ext;
  logic [ID_BITS-1:0]       rd_id;
  logic [DEADLINE_BITS-1:0] rd_dl;
  logic                     accept;
  logic                     id_hit;

  assign k_m1    = k_q - OneC;
  assign pos_ext = CMP_W'(position_i);
  assign cnt_ext = CMP_W'(count_q);
  assign rd_id   = mem_rdata_i[ENTRY_W-1 -: ID_BITS];
  assign rd_dl   = mem_rdata_i[DEADLINE_BITS-1:0];
  assign accept  = start_i && (state_q == S_IDLE) && !rd_pend_q;
  assign id_hit  = (rd_id == id_q);

  // Sequence one request through the memory
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    k_d         = k_q;
    found_d     = found_q;
    rd_pend_d   = 1'b0;
    id_d        = id_q;
    dl_d        = dl_q;
    done_d      = 1'b0;
    status_d    = status_q;
    rid_d       = rid_q;
    rdl_d       = rdl_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = k_q[IDX_W-1:0];
    mem_wdata_o = {id_q, dl_q};
    mem_re_o    = 1'b0;
    mem_raddr_o = k_q[IDX_W-1:0];

    case (state_q)
      S_IDLE: begin
        // A positional read's data comes back here in the cycle after it was issued
        if (rd_pend_q) begin
          done_d   = 1'b1;
          status_d = ST_OK;
          rid_d    = rd_id;
          rdl_d    = rd_dl;
        end else if (accept) begin
          id_d  = item_id_i;
          dl_d  = item_deadline_i;
          rid_d = '0;
          rdl_d = '0;
          case (func_e'(func_i))
            FUNC_INSERT: begin
              if (count_q == DepthC) begin
                done_d   = 1'b1;
                status_d = ST_FULL;
              end else if (count_q == '0) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = '0;
                mem_wdata_o = {item_id_i, item_deadline_i};
                count_d     = count_q + OneC;
                done_d      = 1'b1;
                status_d    = ST_OK;
              end else begin
                k_d     = count_q;
                state_d = S_INS_RD;
              end
            end
            FUNC_REMOVE: begin
              if (count_q == '0) begin
                done_d   = 1'b1;
                status_d = ST_ABSENT;
              end else begin
                k_d     = '0;
                found_d = 1'b0;
                state_d = S_REM_RD;
              end
            end
            FUNC_READ: begin
              if (pos_ext < cnt_ext) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = pos_ext[IDX_W-1:0];
                rd_pend_d   = 1'b1;
              end else begin
                done_d   = 1'b1;
                status_d = ST_ABSENT;
              end
            end
            default: begin
              done_d   = 1'b1;
              status_d = ST_OK;
            end
          endcase
        end
      end

      // Fetch the entry just ahead of the hole
      S_INS_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = k_m1[IDX_W-1:0];
        state_d     = S_INS_CMP;
      end

      // Shift the entry back into the hole, or drop the new entry in
      S_INS_CMP: begin
        if (dl_q <= rd_dl) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = k_q[IDX_W-1:0];
          mem_wdata_o = mem_rdata_i;
          k_d         = k_m1;
          state_d     = (k_m1 == '0) ? S_INS_PUT : S_INS_RD;
        end else begin
          mem_we_o = 1'b1;
          count_d  = count_q + OneC;
          done_d   = 1'b1;
          status_d = ST_OK;
          state_d  = S_IDLE;
        end
      end

      // Place the new entry at the front
      S_INS_PUT: begin
        mem_we_o = 1'b1;
        count_d  = count_q + OneC;
        done_d   = 1'b1;
        status_d = ST_OK;
        state_d  = S_IDLE;
      end

      // Fetch the next entry in the scan
      S_REM_RD: begin
        mem_re_o = 1'b1;
        state_d  = S_REM_CHK;
      end

      // Match the id, or pull the entry up by one once matched
      S_REM_CHK: begin
        if (found_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = k_m1[IDX_W-1:0];
          mem_wdata_o = mem_rdata_i;
        end else if (id_hit) begin
          found_d = 1'b1;
        end
        if (k_q == count_q - OneC) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (found_q || id_hit) begin
            count_d  = count_q - OneC;
            status_d = ST_OK;
          end else begin
            status_d = ST_ABSENT;
          end
        end else begin
          k_d     = k_q + OneC;
          state_d = S_REM_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      k_q       <= '0;
      found_q   <= 1'b0;
      rd_pend_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      k_q       <= k_d;
      found_q   <= found_d;
      rd_pend_q <= rd_pend_d;
      done_q    <= done_d;
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    id_q     <= id_d;
    dl_q     <= dl_d;
    status_q <= status_d;
    rid_q    <= rid_d;
    rdl_q    <= rdl_d;
  end

  assign busy_o          = (state_q != S_IDLE) || rd_pend_q;
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign read_id_o       = rid_q;
  assign read_deadline_o = rdl_q;
  assign occupancy_o     = count_q;

endmodule

// ===== hw/rtl/deadline_ordered_queue.sv =====
// ----------------------------------------------------------------------------
// deadline_ordered_queue
// Sorted-list priority queue of (job id, deadline) entries held in one
// synchronous memory, kept in ascending deadline order.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; its single
// result shows on the result ports for one cycle with done_o high, and must
// be captured then, since the block cannot be held off. An ignored code, a
// refused insert, an insert into an empty queue, a remove on an empty queue
// and a read beyond occupancy answer in the cycle after the request; a positional
// read answers once the registered memory word is back. Any other insert walks
// back from the tail through the entry memory, reading each entry it moves and
// writing it back one slot later, then writes the new entry into the freed
// slot. A remove scans every valid entry, reading each one and writing it back
// one slot up once the matching id has been passed. busy_o drops in the cycle
// the result is shown, so the next request may enter then.
// ----------------------------------------------------------------------------
module deadline_ordered_queue #(
  parameter int unsigned QUEUE_DEPTH   = dlq_pkg::QueueDepthDef,
  parameter int unsigned ID_BITS       = dlq_pkg::IdBitsDef,
  parameter int unsigned DEADLINE_BITS = dlq_pkg::DeadlineBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [dlq_pkg::FuncW-1:0]           func_i,
  input  logic [ID_BITS-1:0]                  item_id_i,
  input  logic [DEADLINE_BITS-1:0]            item_deadline_i,
  input  logic [dlq_pkg::PosW-1:0]            position_i,
  output logic                                done_o,
  output logic [dlq_pkg::StatusW-1:0]         status_o,
  output logic [ID_BITS-1:0]                  read_id_o,
  output logic [DEADLINE_BITS-1:0]            read_deadline_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]    occupancy_o
);
  import dlq_pkg::*;

  localparam int unsigned ENTRY_W = ID_BITS + DEADLINE_BITS;
  localparam int unsigned IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMP_W   = (CNT_W > PosW) ? CNT_W : PosW;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  // Sequencer
  dlq_seq #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .ID_BITS       (ID_BITS),
    .DEADLINE_BITS (DEADLINE_BITS),
    .ENTRY_W       (ENTRY_W),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .func_i          (func_i),
    .item_id_i       (item_id_i),
    .item_deadline_i (item_deadline_i),
    .position_i      (position_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .read_id_o       (read_id_o),
    .read_deadline_o (read_deadline_o),
    .occupancy_o     (occupancy_o),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata)
  );

  // Entry memory
  dlq_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ENTRY_W     (ENTRY_W),
    .IDX_W       (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // A result always lands with the block free for the next request
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("result shown while busy");

  // Occupancy never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy_o <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy beyond depth");

  // A refused insert only happens on a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL)) |-> (occupancy_o == CNT_W'(QUEUE_DEPTH)))
    else $error("insert refused below depth");

  // A read beyond occupancy answers absent in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (func_i == FUNC_READ)
     && (CMP_W'(position_i) >= CMP_W'(occupancy_o)))
    |=> (done_o && (status_o == ST_ABSENT)))
    else $error("read beyond occupancy not flagged");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: deadline ordered queue testbench
// Drives insert, remove and read requests through the start/busy handshake
// and checks every done strobe against a shadow copy of the sorted queue, or
// against an outcome written out by hand. A short table of directed requests
// covers the empty queue, the field extremes, deadline ties, duplicate ids,
// a full queue and the ignored code. It is followed by random bursts that
// sweep the occupancy between empty and full.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import dlq_pkg::*;

  localparam int unsigned Depth  = QueueDepthDef;
  localparam int unsigned IdW    = IdBitsDef;
  localparam int unsigned DlW    = DeadlineBitsDef;
  localparam int unsigned OccW   = $clog2(Depth + 1);
  localparam int unsigned NumReq = 1850;
  localparam int unsigned Drain  = 40;
  localparam int unsigned MaxLog = 10;

  // func code 3 carries no operation
  localparam logic [FuncW-1:0] FuncIgnored = 2'd3;
  localparam logic [DlW-1:0]   DlMax       = '1;

  typedef struct packed {
    status_e             status;
    logic [IdW-1:0]      read_id;
    logic [DlW-1:0]      read_deadline;
    logic [OccW-1:0]     occupancy;
  } outcome_t;

  typedef struct packed {
    logic [FuncW-1:0]    func;
    logic [IdW-1:0]      id;
    logic [DlW-1:0]      deadline;
    logic [PosW-1:0]     pos;
    logic                fixed;
    outcome_t            known;
  } row_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                start_i         = 1'b0;
  logic [FuncW-1:0]    func_i          = '0;
  logic [IdW-1:0]      item_id_i       = '0;
  logic [DlW-1:0]      item_deadline_i = '0;
  logic [PosW-1:0]     position_i      = '0;
  logic                busy_o;
  logic                done_o;
  logic [StatusW-1:0]  status_o;
  logic [IdW-1:0]      read_id_o;
  logic [DlW-1:0]      read_deadline_o;
  logic [OccW-1:0]     occupancy_o;

  // Shadow copy of the sorted queue
  logic [DlW-1:0]      shadow_deadline [Depth];
  logic [IdW-1:0]      shadow_id       [Depth];
  int                  shadow_count = 0;

  outcome_t            pending_outcomes [$];
  row_t                directed_rows    [$];

  int unsigned         mismatch_count = 0;
  int unsigned         results_seen   = 0;
  int unsigned         sent_count     = 0;
  int unsigned         insert_count   = 0;
  int unsigned         refused_count  = 0;
  int unsigned         remove_count   = 0;
  int unsigned         absent_count   = 0;
  int unsigned         read_count     = 0;
  int unsigned         full_hits      = 0;
  int unsigned         empty_hits     = 0;
  bit                  filling        = 1'b0;

  always #2 clk_i = ~clk_i;

  deadline_ordered_queue #(
    .QUEUE_DEPTH   (Depth),
    .ID_BITS       (IdW),
    .DEADLINE_BITS (DlW)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .func_i          (func_i),
    .item_id_i       (item_id_i),
    .item_deadline_i (item_deadline_i),
    .position_i      (position_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .read_id_o       (read_id_o),
    .read_deadline_o (read_deadline_o),
    .occupancy_o     (occupancy_o)
  );

  // Apply one request to the shadow queue and return its outcome
  function automatic outcome_t shadow_apply(input logic [FuncW-1:0] func,
                                            input logic [IdW-1:0] id,
                                            input logic [DlW-1:0] dl,
                                            input logic [PosW-1:0] pos);
    outcome_t o;
    int       slot;
    int       k;
    o = '0;
    o.status = ST_OK;
    if (func == FUNC_INSERT) begin
      if (shadow_count >= Depth) begin
        o.status = ST_FULL;
      end else begin
        // land in front of the first entry whose deadline is not smaller
        slot = shadow_count;
        for (k = shadow_count - 1; k >= 0; k--) begin
          if (dl <= shadow_deadline[k]) slot = k;
        end
        for (k = shadow_count; k > slot; k--) begin
          shadow_deadline[k] = shadow_deadline[k-1];
          shadow_id[k]       = shadow_id[k-1];
        end
        shadow_deadline[slot] = dl;
        shadow_id[slot]       = id;
        shadow_count++;
      end
    end else if (func == FUNC_REMOVE) begin
      // take only the first match, then close the gap
      slot = -1;
      for (k = shadow_count - 1; k >= 0; k--) begin
        if (shadow_id[k] == id) slot = k;
      end
      if (slot < 0) begin
        o.status = ST_ABSENT;
      end else begin
        for (k = slot; k + 1 < shadow_count; k++) begin
          shadow_deadline[k] = shadow_deadline[k+1];
          shadow_id[k]       = shadow_id[k+1];
        end
        shadow_count--;
      end
    end else if (func == FUNC_READ) begin
      if (int'(pos) < shadow_count) begin
        o.read_id       = shadow_id[pos];
        o.read_deadline = shadow_deadline[pos];
      end else begin
        o.status = ST_ABSENT;
      end
    end
    o.occupancy = OccW'(shadow_count);
    return o;
  endfunction

  function automatic row_t req_row(input logic [FuncW-1:0] func,
                                   input logic [IdW-1:0] id,
                                   input logic [DlW-1:0] dl,
                                   input logic [PosW-1:0] pos);
    row_t r;
    r = '0;
    r.func     = func;
    r.id       = id;
    r.deadline = dl;
    r.pos      = pos;
    return r;
  endfunction

  // Row whose outcome is written out by hand
  function automatic row_t req_row_exp(input logic [FuncW-1:0] func,
                                       input logic [IdW-1:0] id,
                                       input logic [DlW-1:0] dl,
                                       input logic [PosW-1:0] pos,
                                       input status_e st,
                                       input logic [IdW-1:0] rid,
                                       input logic [DlW-1:0] rdl,
                                       input logic [OccW-1:0] occ);
    row_t r;
    r = req_row(func, id, dl, pos);
    r.fixed                 = 1'b1;
    r.known.status          = st;
    r.known.read_id         = rid;
    r.known.read_deadline   = rdl;
    r.known.occupancy       = occ;
    return r;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(input row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // Hold the request until the block takes it, then log its outcome
  task automatic send_request(input row_t r);
    outcome_t o;
    start_i         <= 1'b1;
    func_i          <= r.func;
    item_id_i       <= r.id;
    item_deadline_i <= r.deadline;
    position_i      <= r.pos;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    o = shadow_apply(r.func, r.id, r.deadline, r.pos);
    pending_outcomes.insert(pending_outcomes.size(), r.fixed ? r.known : o);
    sent_count++;
    if (r.func == FUNC_INSERT) begin
      insert_count++;
      if (o.status == ST_FULL) refused_count++;
    end else if (r.func == FUNC_REMOVE) begin
      remove_count++;
      if (o.status == ST_ABSENT) absent_count++;
    end else if (r.func == FUNC_READ) begin
      read_count++;
    end
    if (shadow_count == Depth) full_hits++;
    if (shadow_count == 0) empty_hits++;
  endtask

  task automatic idle_cycles(input int unsigned n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Hold off until every outstanding result has come back
  task automatic wait_drained();
    start_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DlW-1:0] pick_deadline();
    case ($urandom_range(0, 4))
      0: return DlW'($urandom_range(0, 7));
      1: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return DlMax;
          default: return DlMax - 1;
        endcase
      end
      2: begin
        if (shadow_count > 0) return shadow_deadline[$urandom_range(0, shadow_count - 1)];
        return DlW'($urandom);
      end
      default: return DlW'($urandom);
    endcase
  endfunction

  // Build one random request, steered by the fill or drain phase
  function automatic row_t random_row();
    row_t        r;
    int unsigned pick;
    r = req_row(FUNC_READ, IdW'($urandom), DlW'($urandom), PosW'($urandom));
    if (shadow_count == Depth) filling = 1'b0;
    if (shadow_count == 0) filling = 1'b1;
    if ($urandom_range(0, 63) == 0) filling = ~filling;
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      r.func = FuncIgnored;
    end else if (pick < 20) begin
      r.func = FUNC_READ;
      if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
        r.pos = PosW'($urandom_range(0, shadow_count - 1));
      end
    end else if (pick < (filling ? 75 : 42)) begin
      r.func     = FUNC_INSERT;
      r.deadline = pick_deadline();
      if ($urandom_range(0, 1) == 0) r.id = IdW'($urandom_range(0, 15));
    end else begin
      r.func = FUNC_REMOVE;
      if (shadow_count > 0 && $urandom_range(0, 4) != 0) begin
        r.id = shadow_id[$urandom_range(0, shadow_count - 1)];
      end else if ($urandom_range(0, 1) == 0) begin
        r.id = IdW'($urandom_range(0, 15));
      end
    end
    return r;
  endfunction

  // Check each done strobe against the oldest outstanding outcome
  always @(posedge clk_i) begin : check_results
    outcome_t want;
    if (rst_ni && done_o === 1'b1) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxLog) begin
          $display("result %0d with no request outstanding: status %0d id %0d",
                   results_seen, status_o, read_id_o);
        end
      end else begin
        want = pending_outcomes.pop_front();
        if (status_o !== want.status || read_id_o !== want.read_id ||
            read_deadline_o !== want.read_deadline ||
            occupancy_o !== want.occupancy) begin
          mismatch_count++;
          if (mismatch_count <= MaxLog) begin
            $display("result %0d: expected status %0d id %0d deadline %h occ %0d",
                     results_seen, want.status, want.read_id, want.read_deadline,
                     want.occupancy);
            $display("           got      status %0d id %0d deadline %h occ %0d",
                     status_o, read_id_o, read_deadline_o, occupancy_o);
          end
        end
      end
    end
  end

  // Main stimulus
  initial begin : stimulus
    int unsigned burst;
    int unsigned gap;
    bit          paused;
    paused = 1'b0;

    // empty queue, ignored code, extremes
    add_row(req_row_exp(FUNC_READ, 0, 0, 0, ST_ABSENT, 0, 0, 0));
    add_row(req_row_exp(FUNC_REMOVE, 5, 0, 0, ST_ABSENT, 0, 0, 0));
    add_row(req_row_exp(FuncIgnored, '1, DlMax, '1, ST_OK, 0, 0, 0));
    add_row(req_row_exp(FUNC_INSERT, 0, 0, 0, ST_OK, 0, 0, 1));
    add_row(req_row_exp(FUNC_INSERT, '1, DlMax, 0, ST_OK, 0, 0, 2));
    // equal deadlines: newest goes first
    add_row(req_row(FUNC_INSERT, 7, 100, 0));
    add_row(req_row(FUNC_INSERT, 8, 100, 0));
    add_row(req_row_exp(FUNC_READ, 0, 0, 3, ST_OK, '1, DlMax, 4));
    // duplicate id: remove takes the first match only
    add_row(req_row(FUNC_INSERT, 7, 50, 0));
    add_row(req_row(FUNC_REMOVE, 7, 0, 0));
    add_row(req_row_exp(FUNC_READ, 0, 0, '1, ST_ABSENT, 0, 0, 4));
    add_row(req_row_exp(FUNC_REMOVE, 999, 0, 0, ST_ABSENT, 0, 0, 4));
    // fill to the top, with ties at both ends
    add_row(req_row(FUNC_INSERT, 100, 32'h8000_0000, 0));
    add_row(req_row(FUNC_INSERT, 101, 1, 0));
    add_row(req_row(FUNC_INSERT, 102, DlMax, 0));
    add_row(req_row(FUNC_INSERT, 103, 100, 0));
    add_row(req_row(FUNC_INSERT, 104, 0, 0));
    add_row(req_row(FUNC_INSERT, 105, 32'h7FFF_FFFF, 0));
    add_row(req_row(FUNC_INSERT, 106, 32'h5555_5555, 0));
    add_row(req_row(FUNC_INSERT, 107, 32'hAAAA_AAAA, 0));
    add_row(req_row(FUNC_INSERT, 108, 200, 0));
    add_row(req_row(FUNC_INSERT, 109, 3, 0));
    add_row(req_row(FUNC_INSERT, 110, DlMax - 1, 0));
    add_row(req_row(FUNC_INSERT, 111, 99, 0));
    add_row(req_row_exp(FUNC_INSERT, 555, 42, 0, ST_FULL, 0, 0, OccW'(Depth)));
    add_row(req_row(FUNC_READ, 0, 0, '1));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_request(directed_rows[i]);
    wait_drained();
    @(posedge clk_i);

    // random bursts; sometimes the gap is zero so bursts run together
    while (sent_count < NumReq) begin
      burst = $urandom_range(1, 24);
      repeat (burst) send_request(random_row());
      if (!paused && sent_count > NumReq / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      idle_cycles(gap);
    end

    wait_drained();
    repeat (Drain) @(posedge clk_i);

    $display("sent %0d requests: %0d inserts (%0d refused full), %0d removes (%0d absent),",
             sent_count, insert_count, refused_count, remove_count, absent_count);
    $display("%0d reads; queue full after %0d requests, empty after %0d; %0d results checked",
             read_count, full_hits, empty_hits, results_seen);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatching results", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_outcomes.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== deadline_ordered_queue.f =====
hw/rtl/dlq_pkg.sv
hw/rtl/dlq_store.sv
hw/rtl/dlq_seq.sv
hw/rtl/deadline_ordered_queue.sv
tb/tb.sv
